/* hw/rtl/modbus_rtu_frame_end_detector_defines.svh */
// Assertion macros used by the frame end detector top level
`ifndef MODBUS_RTU_FRAME_END_DETECTOR_DEFINES_SVH
`define MODBUS_RTU_FRAME_END_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property, checked on every clock edge outside reset
`define MRFED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mrfed: property failed");

// Antecedent in this cycle, consequent in the next one
`define MRFED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mrfed: next-cycle property failed");

`else

`define MRFED_ASSERT(lbl, clk, rstn, prop)
`define MRFED_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/mrfed_pkg.sv */
// Types and constants shared by the frame end detector modules
`default_nettype none

package mrfed_pkg;

  // Frame size limit and count width
  localparam int unsigned MAX_FRAME = 256;
  localparam int unsigned CNT_W     = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;
  localparam logic [7:0]  OWN_ADDR_RESET = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLAVE_MODE  = 1'b0,
    REG_OWN_ADDRESS = 1'b1
  } reg_e;

  // Input commands; code 3 carries no meaning
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_IDLE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic             frame_complete;
    logic [CNT_W-1:0] frame_length;
    logic [7:0]       function_code;
    logic             address_match;
    logic             overflowed;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/modbus_rtu_frame_end_detector.sv */
// Modbus RTU frame end detector: top level with configuration registers
//
// Input channel (in_valid_i / in_stall_o) carries a command and a data byte:
// a received byte, a receive-idle event, or a clear. Only an idle event
// yields a result on the output channel (out_valid_o / out_stall_i), which
// reports whether the bytes gathered so far form a complete frame, the byte
// count, the function code, the address match and the overflow flag.
// One item is taken per cycle while the input is not stalled. An item is
// registered in the input register and is judged on its way into the result
// register, which offers the result to the receiver. While a result is held
// by a stalled receiver, bytes and clears still pass; only a following idle
// event waits in the input register, and then the input stalls.
// Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i): index 0 selects slave
// mode, index 1 the own address; write only while the block is idle.
// Reset puts master mode, address 1, an empty frame and both stages empty;
// no clearing sweep is needed.
`default_nettype none
`include "modbus_rtu_frame_end_detector_defines.svh"

module modbus_rtu_frame_end_detector #(
  parameter int unsigned MaxFrame = mrfed_pkg::MAX_FRAME
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mrfed_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mrfed_pkg::CFG_DAT_W-1:0]     cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          command_i,
  input  wire logic [7:0]                          data_byte_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     frame_complete_o,
  output logic [8:0]                               frame_length_o,
  output logic [7:0]                               function_code_o,
  output logic                                     address_match_o,
  output logic                                     overflowed_o
);

  logic             slave_mode_q;
  logic [7:0]       own_address_q;
  logic             out_space;
  logic             item_fire;
  mrfed_pkg::item_t item;
  logic             res_valid;
  mrfed_pkg::res_t  res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_mode_q  <= 1'b0;
      own_address_q <= mrfed_pkg::OWN_ADDR_RESET;
    end else if (cfg_we_i) begin
      unique case (mrfed_pkg::reg_e'(cfg_index_i))
        mrfed_pkg::REG_SLAVE_MODE:  slave_mode_q  <= cfg_wdata_i[0];
        mrfed_pkg::REG_OWN_ADDRESS: own_address_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  mrfed_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .in_stall_o  (in_stall_o),
    .out_space_i (out_space),
    .item_fire_o (item_fire),
    .item_o      (item)
  );

  mrfed_judge #(
    .MaxFrame (MaxFrame)
  ) u_judge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_fire_i   (item_fire),
    .item_i        (item),
    .slave_mode_i  (slave_mode_q),
    .own_address_i (own_address_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  mrfed_out_stage u_out_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_valid_i      (res_valid),
    .res_i            (res),
    .space_o          (out_space),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .frame_complete_o (frame_complete_o),
    .frame_length_o   (frame_length_o),
    .function_code_o  (function_code_o),
    .address_match_o  (address_match_o),
    .overflowed_o     (overflowed_o)
  );

  // A new result only ever follows an idle event leaving the input register
  `MRFED_ASSERT(a_result_from_idle, clk_i, rst_ni, $rose(out_valid_o) |-> $past(item_fire && (item.cmd == mrfed_pkg::CMD_IDLE)))
  // An idle event that leaves the input register always lands a result
  `MRFED_ASSERT_NEXT(a_idle_gives_result, clk_i, rst_ni, item_fire && (item.cmd == mrfed_pkg::CMD_IDLE), out_valid_o)
  // In slave mode a complete frame must carry our address
  `MRFED_ASSERT(a_slave_addr, clk_i, rst_ni, (out_valid_o && frame_complete_o && slave_mode_q) |-> address_match_o)
  // Reported length never exceeds the frame limit
  `MRFED_ASSERT(a_len_bound, clk_i, rst_ni, out_valid_o |-> (frame_length_o <= 9'(MaxFrame)))

endmodule

`default_nettype wire

/* hw/rtl/mrfed_in_stage.sv */
// Input register stage: holds one item until the judge can take it
`default_nettype none

module mrfed_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    command_i,
  input  wire logic [7:0]    data_byte_i,
  output logic               in_stall_o,
  input  wire logic          out_space_i,
  output logic               item_fire_o,
  output mrfed_pkg::item_t   item_o
);

  logic             valid_q, valid_d;
  mrfed_pkg::item_t item_q;
  logic             take;

  // Only an idle event produces a result, so only it waits for output space
  assign item_fire_o = valid_q && ((item_q.cmd != mrfed_pkg::CMD_IDLE) || out_space_i);
  assign in_stall_o  = valid_q && !item_fire_o;
  assign take        = in_valid_i && !in_stall_o;
  assign item_o      = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (item_fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.cmd  <= mrfed_pkg::cmd_e'(command_i);
      item_q.data <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mrfed_judge.sv */
// Frame state, byte capture and completion judgement, one item per cycle
`default_nettype none

module mrfed_judge #(
  parameter int unsigned MaxFrame = mrfed_pkg::MAX_FRAME
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_fire_i,
  input  wire mrfed_pkg::item_t item_i,
  input  wire logic             slave_mode_i,
  input  wire logic [7:0]       own_address_i,
  output logic                  res_valid_o,
  output mrfed_pkg::res_t       res_o
);

  localparam int unsigned CntW = mrfed_pkg::CNT_W;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxFrame);

  // Byte positions captured from the frame
  localparam logic [CntW-1:0] PosAddr    = CntW'(0);
  localparam logic [CntW-1:0] PosFunc    = CntW'(1);
  localparam logic [CntW-1:0] PosRespCnt = CntW'(2);
  localparam logic [CntW-1:0] PosReqCnt  = CntW'(6);

  // Function codes
  localparam logic [7:0] FcReadCoils      = 8'd1;
  localparam logic [7:0] FcReadInputRegs  = 8'd4;
  localparam logic [7:0] FcWriteCoil      = 8'd5;
  localparam logic [7:0] FcWriteReg       = 8'd6;
  localparam logic [7:0] FcWriteCoils     = 8'd15;
  localparam logic [7:0] FcWriteRegs      = 8'd16;
  localparam int unsigned FcExceptionBit  = 7;

  // Length thresholds
  localparam logic [CntW-1:0] LenMin      = CntW'(4);
  localparam logic [CntW-1:0] LenExcept   = CntW'(5);
  localparam logic [CntW-1:0] LenFixed    = CntW'(8);
  localparam logic [CntW:0]   RespOverhd  = (CntW+1)'(5);
  localparam logic [CntW:0]   ReqOverhd   = (CntW+1)'(9);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      func_q, func_d;
  logic [7:0]      rbc_q, rbc_d;
  logic [7:0]      qbc_q, qbc_d;
  logic            ovf_q, ovf_d;

  logic match, resp_done, req_done, done;

  assign match = (first_q == own_address_i);

  // Response length check (master)
  always_comb begin
    resp_done = 1'b0;
    if (cnt_q >= LenMin) begin
      case (func_q) inside
        [FcReadCoils:FcReadInputRegs]:
          resp_done = ({1'b0, cnt_q} >= (RespOverhd + (CntW+1)'(rbc_q)));
        FcWriteCoil, FcWriteReg, FcWriteCoils, FcWriteRegs:
          resp_done = (cnt_q >= LenFixed);
        default:
          resp_done = func_q[FcExceptionBit] && (cnt_q >= LenExcept);
      endcase
    end
  end

  // Request length check (slave), exact lengths
  always_comb begin
    req_done = 1'b0;
    if (cnt_q >= LenMin) begin
      case (func_q) inside
        [FcReadCoils:FcWriteReg]:
          req_done = (cnt_q == LenFixed);
        FcWriteCoils, FcWriteRegs:
          req_done = ({1'b0, cnt_q} == (ReqOverhd + (CntW+1)'(qbc_q)));
        default:
          req_done = 1'b0;
      endcase
    end
  end

  assign done = slave_mode_i ? (req_done && match) : resp_done;

  // Result fields straight from the current state
  assign res_o.frame_complete = done;
  assign res_o.frame_length   = cnt_q;
  assign res_o.function_code  = func_q;
  assign res_o.address_match  = match;
  assign res_o.overflowed     = ovf_q;

  // Next state per command
  always_comb begin
    cnt_d       = cnt_q;
    first_d     = first_q;
    func_d      = func_q;
    rbc_d       = rbc_q;
    qbc_d       = qbc_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    if (item_fire_i) begin
      unique case (item_i.cmd)
        mrfed_pkg::CMD_BYTE: begin
          if (cnt_q >= MaxCnt) begin
            ovf_d = 1'b1;
          end else begin
            case (cnt_q)
              PosAddr:    first_d = item_i.data;
              PosFunc:    func_d  = item_i.data;
              PosRespCnt: rbc_d   = item_i.data;
              PosReqCnt:  qbc_d   = item_i.data;
              default:    ;
            endcase
            cnt_d = cnt_q + CntW'(1);
          end
        end
        mrfed_pkg::CMD_IDLE: begin
          res_valid_o = 1'b1;
          if (done || slave_mode_i) begin
            cnt_d   = '0;
            first_d = '0;
            func_d  = '0;
            rbc_d   = '0;
            qbc_d   = '0;
            ovf_d   = 1'b0;
          end
        end
        mrfed_pkg::CMD_CLEAR: begin
          cnt_d   = '0;
          first_d = '0;
          func_d  = '0;
          rbc_d   = '0;
          qbc_d   = '0;
          ovf_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= '0;
      func_q  <= '0;
      rbc_q   <= '0;
      qbc_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      first_q <= first_d;
      func_q  <= func_d;
      rbc_q   <= rbc_d;
      qbc_q   <= qbc_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mrfed_out_stage.sv */
// Result register: holds one result until the receiver takes it
`default_nettype none

module mrfed_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            res_valid_i,
  input  wire mrfed_pkg::res_t res_i,
  output logic                 space_o,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output logic                 frame_complete_o,
  output logic [8:0]           frame_length_o,
  output logic [7:0]           function_code_o,
  output logic                 address_match_o,
  output logic                 overflowed_o
);

  logic            valid_q, valid_d;
  mrfed_pkg::res_t res_q;

  // Room when empty or when the held result leaves this cycle
  assign space_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign frame_complete_o = res_q.frame_complete;
  assign frame_length_o   = res_q.frame_length;
  assign function_code_o  = res_q.function_code;
  assign address_match_o  = res_q.address_match;
  assign overflowed_o     = res_q.overflowed;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the Modbus RTU frame end detector
`timescale 1ns / 100ps

module tb_top;
  import mrfed_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CFG_SETTLE   = 4;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           command_i;
  logic [7:0]           data_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 frame_complete_o;
  logic [8:0]           frame_length_o;
  logic [7:0]           function_code_o;
  logic                 address_match_o;
  logic                 overflowed_o;

  // Idle cycles and receiver back-pressure are switched off for one stretch of the run
  bit quiet;
  int unsigned items_sent;
  int unsigned cycles;

  // Tracks the frame state and holds the verdicts still to come out
  class frame_end_tracker;
    bit          slave_mode;
    logic [7:0]  own_addr;
    logic [8:0]  byte_cnt;
    logic [7:0]  addr_byte;
    logic [7:0]  func_byte;
    logic [7:0]  resp_cnt;
    logic [7:0]  req_cnt;
    bit          ovf;
    res_t        pending_verdicts[$];
    int          errors;

    function new();
      slave_mode = 1'b0;
      own_addr   = OWN_ADDR_RESET;
      errors     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_cnt  = '0;
      addr_byte = '0;
      func_byte = '0;
      resp_cnt  = '0;
      req_cnt   = '0;
      ovf       = 1'b0;
    endfunction

    function void set_register(reg_e idx, logic [CFG_DAT_W-1:0] val);
      if (idx == REG_SLAVE_MODE) begin
        slave_mode = val[0];
      end else begin
        own_addr = val[7:0];
      end
    endfunction

    // Master side: responses, "at least" thresholds
    function bit response_complete(int len);
      if (len < 4) return 1'b0;
      if (func_byte >= 8'd1 && func_byte <= 8'd4) return len >= 5 + int'(resp_cnt);
      if (func_byte == 8'd5 || func_byte == 8'd6 || func_byte == 8'd15 ||
          func_byte == 8'd16) return len >= 8;
      if (func_byte[7]) return len >= 5;
      return 1'b0;
    endfunction

    // Slave side: requests, exact length
    function bit request_complete(int len);
      if (len < 4) return 1'b0;
      if (func_byte >= 8'd1 && func_byte <= 8'd6) return len == 8;
      if (func_byte == 8'd15 || func_byte == 8'd16) return len == 9 + int'(req_cnt);
      return 1'b0;
    endfunction

    function void note_transfer(logic [1:0] cmd, logic [7:0] data);
      res_t v;
      bit   done;
      bit   match;
      if (cmd == CMD_BYTE) begin
        // bytes beyond the frame limit are dropped and flagged
        if (int'(byte_cnt) >= MAX_FRAME) begin
          ovf = 1'b1;
        end else begin
          case (int'(byte_cnt))
            0: addr_byte = data;
            1: func_byte = data;
            2: resp_cnt  = data;
            6: req_cnt   = data;
            default: ;
          endcase
          byte_cnt = byte_cnt + 9'd1;
        end
      end else if (cmd == CMD_CLEAR) begin
        clear_frame();
      end else if (cmd == CMD_IDLE) begin
        match = (addr_byte == own_addr);
        if (slave_mode) done = request_complete(int'(byte_cnt)) && match;
        else            done = response_complete(int'(byte_cnt));
        v.frame_complete = done;
        v.frame_length   = byte_cnt;
        v.function_code  = func_byte;
        v.address_match  = match;
        v.overflowed     = ovf;
        pending_verdicts.push_back(v);
        if (done || slave_mode) clear_frame();
      end
    endfunction

    function void check_verdict(res_t got);
      res_t e;
      if (pending_verdicts.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      e = pending_verdicts.pop_front();
      if (got.frame_complete !== e.frame_complete) begin
        $error("frame_complete: expected %0d, got %0d", e.frame_complete, got.frame_complete);
        errors++;
      end
      if (got.frame_length !== e.frame_length) begin
        $error("frame_length: expected %0d, got %0d", e.frame_length, got.frame_length);
        errors++;
      end
      if (got.function_code !== e.function_code) begin
        $error("function_code: expected %0d, got %0d", e.function_code, got.function_code);
        errors++;
      end
      if (got.address_match !== e.address_match) begin
        $error("address_match: expected %0d, got %0d", e.address_match, got.address_match);
        errors++;
      end
      if (got.overflowed !== e.overflowed) begin
        $error("overflowed: expected %0d, got %0d", e.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  frame_end_tracker sb = new();

  modbus_rtu_frame_end_detector uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_complete_o (frame_complete_o),
    .frame_length_o   (frame_length_o),
    .function_code_o  (function_code_o),
    .address_match_o  (address_match_o),
    .overflowed_o     (overflowed_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 32);
  end

  // Result monitor: one transfer per edge with valid high and stall low
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.frame_complete = frame_complete_o;
      got.frame_length   = frame_length_o;
      got.function_code  = function_code_o;
      got.address_match  = address_match_o;
      got.overflowed     = overflowed_o;
      sb.check_verdict(got);
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic drive_item(logic [1:0] cmd, logic [7:0] data);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(cmd, data);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Register write once the block has drained
  task automatic write_reg(reg_e idx, logic [CFG_DAT_W-1:0] val);
    in_valid_i <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, val);
  endtask

  // A frame shaped for the current mode, sometimes a byte short or long
  task automatic send_frame();
    logic [7:0] addr;
    logic [7:0] fn;
    logic [7:0] cnt;
    logic [7:0] b;
    int len;
    int split;
    addr = (sb.slave_mode && $urandom_range(99) < 75) ? sb.own_addr : 8'($urandom);
    cnt  = 8'($urandom_range(12));
    if ($urandom_range(19) == 0) cnt = 8'($urandom);
    case ($urandom_range(9))
      0, 1, 6: fn = 8'($urandom_range(1, 4));
      2, 7:    fn = 8'($urandom_range(5, 6));
      3, 8:    fn = $urandom_range(1) ? 8'd15 : 8'd16;
      4:       fn = 8'h80 | 8'($urandom);
      default: fn = 8'($urandom);
    endcase
    if (sb.slave_mode) begin
      len = (fn == 8'd15 || fn == 8'd16) ? 9 + int'(cnt) : 8;
    end else if (fn >= 8'd1 && fn <= 8'd4) begin
      len = 5 + int'(cnt);
    end else if (fn == 8'd5 || fn == 8'd6 || fn == 8'd15 || fn == 8'd16) begin
      len = 8;
    end else if (fn[7]) begin
      len = 5;
    end else begin
      len = $urandom_range(1, 12);
    end
    // unreachable thresholds stay short frames
    if (len > 24) len = $urandom_range(4, 24);
    if ($urandom_range(4) == 0) len = $urandom_range(1) ? len + 1 : len - 1;
    if (len < 1) len = 1;
    // responses may arrive over more than one burst
    split = (!sb.slave_mode && len > 1 && $urandom_range(3) == 0) ?
            $urandom_range(1, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == 0)                b = addr;
      else if (i == 1)           b = fn;
      else if (i == 2 || i == 6) b = cnt;
      else                       b = 8'($urandom);
      if (i == split) drive_item(CMD_IDLE, 8'($urandom));
      drive_item(CMD_BYTE, b);
    end
    drive_item(CMD_IDLE, 8'($urandom));
  endtask

  // Short run of any command, the unused code included
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) drive_item(2'($urandom_range(3)), 8'($urandom));
  endtask

  // Runs past the frame limit so that excess bytes are dropped
  task automatic send_burst();
    int n;
    n = MAX_FRAME + $urandom_range(1, 4);
    repeat (n) drive_item(CMD_BYTE, 8'($urandom));
    drive_item(CMD_IDLE, 8'($urandom));
  endtask

  task automatic run_phase(bit mode, logic [7:0] addr, int n_items, bit burst, bit no_idle);
    int target;
    write_reg(REG_SLAVE_MODE, {7'($urandom), mode});
    write_reg(REG_OWN_ADDRESS, addr);
    quiet = no_idle;
    if (burst) send_burst();
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) send_frame();
      else                         send_noise();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_SLAVE_MODE;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    command_i   <= CMD_BYTE;
    data_byte_i <= '0;
    out_stall_i <= 1'b0;
    quiet       = 1'b0;
    items_sent  = 0;
    cycles      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: master mode straight out of reset
    drive_item(CMD_IDLE, 8'h00);      // empty frame
    drive_item(CMD_UNUSED, 8'hFF);    // unused code gives nothing
    drive_item(CMD_BYTE, 8'h01);
    drive_item(CMD_BYTE, 8'h03);      // read, count 0
    drive_item(CMD_BYTE, 8'h00);
    drive_item(CMD_IDLE, 8'hFF);      // under four bytes
    drive_item(CMD_BYTE, 8'hFF);
    drive_item(CMD_BYTE, 8'h00);
    drive_item(CMD_IDLE, 8'h00);      // five bytes completes the read
    drive_item(CMD_BYTE, 8'h00);
    drive_item(CMD_BYTE, 8'h83);      // exception response
    drive_item(CMD_BYTE, 8'h02);
    drive_item(CMD_BYTE, 8'h7F);
    drive_item(CMD_IDLE, 8'h00);      // four bytes, not yet
    drive_item(CMD_BYTE, 8'h80);
    drive_item(CMD_IDLE, 8'h00);      // accumulated to five
    drive_item(CMD_BYTE, 8'h01);
    drive_item(CMD_BYTE, 8'h10);
    drive_item(CMD_CLEAR, 8'hAA);     // clear mid-frame
    drive_item(CMD_IDLE, 8'h55);

    // Random phases over both modes and the address extremes
    run_phase(1'b0, 8'h01, 100, 1'b1, 1'b0);
    run_phase(1'b1, 8'h01, 100, 1'b0, 1'b0);
    run_phase(1'b1, 8'h00, 100, 1'b0, 1'b1);
    run_phase(1'b1, 8'hFF, 100, 1'b1, 1'b0);
    run_phase(1'b0, 8'hFF, 80, 1'b0, 1'b0);
    run_phase(1'b1, 8'($urandom), 80, 1'b0, 1'b0);
    run_phase(1'b0, 8'h00, 60, 1'b0, 1'b0);

    // Drain and finish
    in_valid_i <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_verdicts.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* modbus_rtu_frame_end_detector.f */
+incdir+hw/rtl
hw/rtl/mrfed_pkg.sv
hw/rtl/mrfed_in_stage.sv
hw/rtl/mrfed_judge.sv
hw/rtl/mrfed_out_stage.sv
hw/rtl/modbus_rtu_frame_end_detector.sv
test/tb_top.sv
